// ----- hw/rtl/graph_traversal_bfs_dfs_assert.svh -----
// Assertion macros shared by the graph traversal RTL.
`ifndef GRAPH_TRAVERSAL_BFS_DFS_ASSERT_SVH
`define GRAPH_TRAVERSAL_BFS_DFS_ASSERT_SVH

// Same-cycle implication, checked on clk with reset rst_n.
`define GTBD_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("gtbd: implication check failed");

// Next-cycle implication, checked on clk with reset rst_n.
`define GTBD_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("gtbd: next-cycle check failed");

`endif

// ----- hw/rtl/gtbd_pkg.sv -----
// Package with the codes, widths and defaults of the graph traversal engine.
`timescale 1ns / 1ps
package gtbd_pkg;

  localparam int VERT_W      = 4;
  localparam int VERT_MAX    = 16;
  localparam int VCOUNT_W    = 5;
  localparam int CMD_W       = 2;
  localparam int STATUS_W    = 2;
  localparam int MAX_RESULTS = 16;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam int VERTICES_DEF  = 16;
  localparam int MAX_EDGES_DEF = 64;

  localparam logic [VCOUNT_W-1:0] VCOUNT_RST = 5'd16;

  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_BFS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DFS   = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd3;

  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

endpackage

// ----- hw/rtl/graph_traversal_bfs_dfs.sv -----
// Top level of the breadth-first and depth-first graph traversal engine.
// Usage: a command is taken at a rising edge with start high and busy low.
// Commands are add edge, breadth-first walk, depth-first walk and clear.
// Every command gives result beats on out_valid, one cycle each; out_last
// marks the final beat of a command and out_status reports range or full.
// Add edge, clear and rejected commands answer in the cycle after acceptance
// and leave busy low, so such commands may follow each other every cycle.
// A traversal raises busy and gives one beat per processed vertex. Each
// processed vertex scans the edge RAM at one entry per cycle; a stale stack
// entry in the depth-first walk is popped and dropped without a beat.
// The edge list and the work queue/stack live in two RAMs with registered
// read data; the visited map is a register.
// The vertex_count register is written on the cfg channel while idle.
// Reset (synchronous, rst_n low) empties the graph and sets vertex_count
// to 16. The receiver cannot stall: every beat is taken when it appears.
`timescale 1ns / 1ps
`include "graph_traversal_bfs_dfs_assert.svh"
module graph_traversal_bfs_dfs #(
  parameter int VERTICES  = gtbd_pkg::VERTICES_DEF,
  parameter int MAX_EDGES = gtbd_pkg::MAX_EDGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [gtbd_pkg::CMD_W-1:0]    in_command,
  input  logic [gtbd_pkg::VERT_W-1:0]   in_vertex_a,
  input  logic [gtbd_pkg::VERT_W-1:0]   in_vertex_b,
  output logic                          out_valid,
  output logic [gtbd_pkg::VERT_W-1:0]   out_vertex,
  output logic                          out_last,
  output logic [gtbd_pkg::STATUS_W-1:0] out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gtbd_pkg::VCOUNT_W-1:0] cfg_vertex_count
);
  import gtbd_pkg::*;

  localparam int VLIM     = (VERTICES < VERT_MAX) ? VERTICES : VERT_MAX;
  localparam int CW       = $clog2(MAX_EDGES + 1);
  localparam int EAW      = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int WORK_CAP = 2 * MAX_EDGES + 1;
  localparam int WAW      = $clog2(WORK_CAP);
  localparam int WTW      = $clog2(WORK_CAP + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP,
    ST_CUR,
    ST_EXP,
    ST_FIN
  } state_t;

  state_t                state_r, state_nxt;
  logic [VCOUNT_W-1:0]   vcount_r, vcount_nxt;
  logic [CW-1:0]         ecnt_r, ecnt_nxt;
  logic [CW-1:0]         eidx_r, eidx_nxt;
  logic                  edv_r, edv_nxt;
  logic [VERT_MAX-1:0]   visited_r, visited_nxt;
  logic [WTW-1:0]        head_r, head_nxt;
  logic [WTW-1:0]        tail_r, tail_nxt;
  logic [NRES_W-1:0]     nres_r, nres_nxt;
  logic                  bfs_r, bfs_nxt;
  logic [VERT_W-1:0]     cur_r, cur_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [VERT_W-1:0]     pend_r, pend_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [VERT_W-1:0]     out_vertex_r, out_vertex_nxt;
  logic                  out_last_r, out_last_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  logic                  e_we, e_re;
  logic [EAW-1:0]        e_waddr, e_raddr;
  logic [2*VERT_W-1:0]   e_wdata, e_rdata;
  logic                  w_we, w_re;
  logic [WAW-1:0]        w_waddr, w_raddr;
  logic [VERT_W-1:0]     w_wdata, w_rdata;

  logic [VCOUNT_W-1:0]   lim;
  logic                  a_bad, b_bad;
  logic [WTW-1:0]        tail_dec;
  logic [VERT_W-1:0]     ea, eb, nb;
  logic                  hit;

  gtbd_ram #(.WIDTH(2 * VERT_W), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (e_waddr),
    .wdata (e_wdata),
    .re    (e_re),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  gtbd_ram #(.WIDTH(VERT_W), .DEPTH(WORK_CAP)) u_work_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .re    (w_re),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  assign lim      = (vcount_r < VCOUNT_W'(VLIM)) ? vcount_r : VCOUNT_W'(VLIM);
  assign a_bad    = VCOUNT_W'(in_vertex_a) >= lim;
  assign b_bad    = VCOUNT_W'(in_vertex_b) >= lim;
  assign tail_dec = tail_r - WTW'(1);
  assign ea       = e_rdata[VERT_W-1:0];
  assign eb       = e_rdata[2*VERT_W-1:VERT_W];
  assign hit      = (ea == cur_r) || (eb == cur_r);
  assign nb       = (ea == cur_r) ? eb : ea;

  assign busy       = (state_r != ST_IDLE);
  assign cfg_ready  = (state_r == ST_IDLE);
  assign out_valid  = out_valid_r;
  assign out_vertex = out_vertex_r;
  assign out_last   = out_last_r;
  assign out_status = out_status_r;

  always_comb begin
    state_nxt      = state_r;
    vcount_nxt     = vcount_r;
    ecnt_nxt       = ecnt_r;
    eidx_nxt       = eidx_r;
    edv_nxt        = edv_r;
    visited_nxt    = visited_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    nres_nxt       = nres_r;
    bfs_nxt        = bfs_r;
    cur_nxt        = cur_r;
    pend_v_nxt     = pend_v_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = 1'b0;
    out_vertex_nxt = '0;
    out_last_nxt   = 1'b0;
    out_status_nxt = STAT_OK;
    e_we           = 1'b0;
    e_waddr        = ecnt_r[EAW-1:0];
    e_wdata        = {in_vertex_b, in_vertex_a};
    e_re           = 1'b0;
    e_raddr        = eidx_r[EAW-1:0];
    w_we           = 1'b0;
    w_waddr        = tail_r[WAW-1:0];
    w_wdata        = nb;
    w_re           = 1'b0;
    w_raddr        = head_r[WAW-1:0];

    if (cfg_valid && cfg_ready) begin
      vcount_nxt = cfg_vertex_count;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_command)
            CMD_CLEAR: begin
              ecnt_nxt      = '0;
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
            end
            CMD_ADD: begin
              out_valid_nxt = 1'b1;
              out_last_nxt  = 1'b1;
              if (a_bad || b_bad) begin
                out_status_nxt = STAT_RANGE;
              end else if (ecnt_r == CW'(MAX_EDGES)) begin
                out_status_nxt = STAT_FULL;
              end else begin
                e_we     = 1'b1;
                ecnt_nxt = ecnt_r + CW'(1);
              end
            end
            default: begin
              if (a_bad) begin
                out_valid_nxt  = 1'b1;
                out_last_nxt   = 1'b1;
                out_status_nxt = STAT_RANGE;
              end else begin
                bfs_nxt     = (in_command == CMD_BFS);
                visited_nxt = '0;
                if (in_command == CMD_BFS) begin
                  visited_nxt[in_vertex_a] = 1'b1;
                end
                w_we       = 1'b1;
                w_waddr    = '0;
                w_wdata    = in_vertex_a;
                head_nxt   = '0;
                tail_nxt   = WTW'(1);
                nres_nxt   = '0;
                pend_v_nxt = 1'b0;
                state_nxt  = ST_POP;
              end
            end
          endcase
        end
      end
      ST_POP: begin
        if (bfs_r) begin
          if (head_r < tail_r) begin
            w_re      = 1'b1;
            w_raddr   = head_r[WAW-1:0];
            head_nxt  = head_r + WTW'(1);
            state_nxt = ST_CUR;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          if (tail_r != '0) begin
            w_re      = 1'b1;
            w_raddr   = tail_dec[WAW-1:0];
            tail_nxt  = tail_dec;
            state_nxt = ST_CUR;
          end else begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_CUR: begin
        if (!bfs_r && visited_r[w_rdata]) begin
          state_nxt = ST_POP;
        end else begin
          visited_nxt[w_rdata] = 1'b1;
          if (pend_v_r) begin
            out_valid_nxt  = 1'b1;
            out_vertex_nxt = pend_r;
          end
          pend_nxt   = w_rdata;
          pend_v_nxt = 1'b1;
          cur_nxt    = w_rdata;
          nres_nxt   = nres_r + NRES_W'(1);
          eidx_nxt   = '0;
          edv_nxt    = 1'b0;
          if (nres_r == NRES_W'(MAX_RESULTS - 1)) begin
            state_nxt = ST_FIN;
          end else begin
            state_nxt = ST_EXP;
          end
        end
      end
      ST_EXP: begin
        if (edv_r && hit && (VCOUNT_W'(nb) < lim) && !visited_r[nb] &&
            (tail_r < WTW'(WORK_CAP))) begin
          w_we     = 1'b1;
          w_waddr  = tail_r[WAW-1:0];
          tail_nxt = tail_r + WTW'(1);
          if (bfs_r) begin
            visited_nxt[nb] = 1'b1;
          end
        end
        if (eidx_r < ecnt_r) begin
          e_re     = 1'b1;
          e_raddr  = eidx_r[EAW-1:0];
          eidx_nxt = eidx_r + CW'(1);
          edv_nxt  = 1'b1;
        end else begin
          edv_nxt = 1'b0;
          if (!edv_r) begin
            state_nxt = ST_POP;
          end
        end
      end
      ST_FIN: begin
        out_valid_nxt  = 1'b1;
        out_vertex_nxt = pend_r;
        out_last_nxt   = 1'b1;
        pend_v_nxt     = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= VCOUNT_RST;
      ecnt_r      <= '0;
      edv_r       <= 1'b0;
      visited_r   <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      nres_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vcount_r    <= vcount_nxt;
      ecnt_r      <= ecnt_nxt;
      edv_r       <= edv_nxt;
      visited_r   <= visited_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      nres_r      <= nres_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    eidx_r       <= eidx_nxt;
    bfs_r        <= bfs_nxt;
    cur_r        <= cur_nxt;
    pend_r       <= pend_nxt;
    out_vertex_r <= out_vertex_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
  end

  `GTBD_ASSERT_IMP(a_idle_no_pending, state_r == ST_IDLE, !pend_v_r)
  `GTBD_ASSERT_IMP(a_work_port_excl, w_re, !w_we)
  `GTBD_ASSERT_IMP(a_result_bound, busy, nres_r <= NRES_W'(MAX_RESULTS))
  `GTBD_ASSERT_IMP(a_last_when_idle, out_valid_r && out_last_r, state_r == ST_IDLE)
  `GTBD_ASSERT_NXT(a_walk_busy, start && !busy && (in_command == CMD_BFS || in_command == CMD_DFS) && !a_bad, busy && !out_valid_r)

endmodule

// ----- hw/rtl/gtbd_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module gtbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
